FILE: sv/rc5_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared types, constants and helpers for the RC5-32 block encryptor.
// ----------------------------------------------------------------------------
package rc5_pkg;

  localparam int WORD_W     = 32;
  localparam int ROT_W      = 5;
  localparam int KEY_IDX_W  = 5;
  localparam int ROUNDS_DEF = 12;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ENCRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic whiten;
  } rnd_ctrl_t;

  function automatic word_t rotl(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] tmp;
    tmp = {x, x} << n;
    return tmp[2*WORD_W-1:WORD_W];
  endfunction

endpackage
`default_nettype wire

FILE: sv/rc5_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_if
// Valid/ready channels for the RC5 encryptor: input words and result words.
// ----------------------------------------------------------------------------
interface rc5_in_if import rc5_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [KEY_IDX_W-1:0] key_index;
  word_t                key_word;
  word_t                first_word;
  word_t                second_word;

  modport source (
    output valid, action, key_index, key_word, first_word, second_word,
    input  ready
  );
  modport sink (
    input  valid, action, key_index, key_word, first_word, second_word,
    output ready
  );
endinterface

interface rc5_out_if import rc5_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t cipher_first;
  word_t cipher_second;

  modport source (
    output valid, cipher_first, cipher_second,
    input  ready
  );
  modport sink (
    input  valid, cipher_first, cipher_second,
    output ready
  );
endinterface
`default_nettype wire

FILE: sv/rc5_block_encrypt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_block_encrypt
// RC5-32 block encryption (ECB) with a loadable expanded-key store.
// ----------------------------------------------------------------------------
// Load words (action 0) write one subkey into a 2*ROUNDS+2 entry RAM and
// produce no result; a slot index past the store is dropped. Every
// subkey an encrypt word uses must be loaded first. Encrypt words (action 1)
// run key whitening plus ROUNDS rounds through a single round unit, one step
// per cycle, the last step holding while an earlier result waits; the two
// subkeys of each step come from the RAM's two registered read ports, fetched
// one step ahead. The next word is taken in the cycle the result is written
// to the output register, and that register frees the input side while a
// result waits downstream.
// ----------------------------------------------------------------------------
module rc5_block_encrypt import rc5_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rc5_in_if.sink     in_i,
  rc5_out_if.source  out_o
);

  localparam int KEY_SLOTS = 2 * ROUNDS + 2;
  localparam int STEP_W    = $clog2(ROUNDS + 1);
  localparam int AW        = STEP_W + 1;
  localparam logic [STEP_W-1:0] LAST = STEP_W'(ROUNDS);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  word_t             a_q;
  word_t             b_q;
  logic              out_valid_q;
  word_t             out_first_q;
  word_t             out_second_q;

  logic              last_step;
  logic              out_free;
  logic              finishing;
  logic              in_accept;
  logic              key_we;
  logic [STEP_W-1:0] rd_row;
  word_t             s_even;
  word_t             s_odd;
  word_t             a_nxt;
  word_t             b_nxt;
  rnd_ctrl_t         rnd_ctrl;

  assign last_step = (state_q == ST_RUN) && (step_q == LAST);
  assign out_free  = !out_valid_q || out_o.ready;
  assign finishing = last_step && out_free;
  assign in_i.ready = (state_q == ST_IDLE) || finishing;
  assign in_accept  = in_i.valid && in_i.ready;
  assign key_we     = in_accept && (in_i.action == ACT_LOAD) &&
                      (32'(in_i.key_index) < 32'(KEY_SLOTS));

  // fetch one step ahead; hold the last pair while the result stalls
  always_comb begin
    rd_row = '0;
    if (state_q == ST_RUN && !finishing) begin
      rd_row = last_step ? LAST : step_q + STEP_W'(1);
    end
  end

  assign rnd_ctrl.whiten = (step_q == '0);

  rc5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk_i    (clk_i),
    .we_i     (key_we),
    .waddr_i  (AW'(in_i.key_index)),
    .wdata_i  (in_i.key_word),
    .raddr0_i ({rd_row, 1'b0}),
    .raddr1_i ({rd_row, 1'b1}),
    .rdata0_o (s_even),
    .rdata1_o (s_odd)
  );

  rc5_round u_round (
    .ctrl_i   (rnd_ctrl),
    .a_i      (a_q),
    .b_i      (b_q),
    .s_even_i (s_even),
    .s_odd_i  (s_odd),
    .a_o      (a_nxt),
    .b_o      (b_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      a_q          <= '0;
      b_q          <= '0;
      out_valid_q  <= 1'b0;
      out_first_q  <= '0;
      out_second_q <= '0;
    end else begin
      if (finishing) begin
        out_first_q  <= a_nxt;
        out_second_q <= b_nxt;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept && in_i.action == ACT_ENCRYPT) begin
        a_q     <= in_i.first_word;
        b_q     <= in_i.second_word;
        step_q  <= '0;
        state_q <= ST_RUN;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
          end
          ST_RUN: begin
            if (!last_step) begin
              a_q    <= a_nxt;
              b_q    <= b_nxt;
              step_q <= step_q + STEP_W'(1);
            end else if (out_free) begin
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_first  = out_first_q;
  assign out_o.cipher_second = out_second_q;

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q != LAST) |-> !in_i.ready)
    else $error("input taken while a block is in progress");

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(last_step && out_free))
    else $error("result raised without a final round");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST)
    else $error("round counter out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_step && !out_free) |=> (state_q == ST_RUN && step_q == LAST))
    else $error("final round lost while output stalled");

endmodule
`default_nettype wire

FILE: sv/rc5_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule
`default_nettype wire

FILE: sv/rc5_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_round
// Shared RC5 round datapath: key whitening or one full round on (A, B).
// ----------------------------------------------------------------------------
module rc5_round import rc5_pkg::*; (
  input  wire rnd_ctrl_t ctrl_i,
  input  wire word_t     a_i,
  input  wire word_t     b_i,
  input  wire word_t     s_even_i,
  input  wire word_t     s_odd_i,
  output word_t          a_o,
  output word_t          b_o
);

  word_t a_rnd;
  word_t b_rnd;

  always_comb begin
    a_rnd = s_even_i + rotl(a_i ^ b_i, b_i[ROT_W-1:0]);
    b_rnd = s_odd_i + rotl(b_i ^ a_rnd, a_rnd[ROT_W-1:0]);
    if (ctrl_i.whiten) begin
      a_o = a_i + s_even_i;
      b_o = b_i + s_odd_i;
    end else begin
      a_o = a_rnd;
      b_o = b_rnd;
    end
  end

endmodule
`default_nettype wire
